// ----- hdl/mtmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmq_pkg
// Shared types and codes for the message tag matching queues.
// ----------------------------------------------------------------------------
package mtmq_pkg;

  typedef enum logic [2:0] {
    REQ_SEND        = 3'd0,
    REQ_RECV        = 3'd1,
    REQ_PROBE       = 3'd2,
    REQ_MPROBE      = 3'd3,
    REQ_CANCEL_SEND = 3'd4,
    REQ_CANCEL_RECV = 3'd5
  } req_t;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [15:0] ANY_TAG = 16'hFFFF;

  // One queue entry.
  typedef struct packed {
    logic        valid;
    logic [15:0] ctx;
    logic [15:0] tag;
    logic [31:0] size;
    logic [7:0]  id;
  } entry_t;

  // Search key broadcast to every cell.
  typedef struct packed {
    logic        by_id;
    logic [15:0] ctx;
    logic [15:0] tag;
    logic [7:0]  id;
  } key_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic   remove;
    logic   append;
    entry_t fresh;
  } upd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_RESOLVE
  } fsm_t;

endpackage

// ----- hdl/mtmq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmq_cell
// One queue slot: holds an entry, compares it with the key, and shifts.
// ----------------------------------------------------------------------------
module mtmq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  mtmq_pkg::key_t   key,
  input  mtmq_pkg::upd_t   upd,
  input  logic             hit_before,   // an older cell matched
  input  logic             free_before,  // an older cell is free
  input  mtmq_pkg::entry_t from_younger,
  output mtmq_pkg::entry_t entry,
  output logic             hit_reg,      // registered match flag
  output logic             hit_out,      // chained to the younger neighbor
  output logic             free_out
);

  mtmq_pkg::entry_t entry_r, entry_nxt;
  logic             hit_r, hit_nxt;
  logic             cmp;

  // Compare against the key.
  always_comb begin
    if (key.by_id) begin
      cmp = entry_r.valid && (entry_r.id == key.id);
    end else begin
      cmp = entry_r.valid && (entry_r.ctx == key.ctx) &&
            ((entry_r.tag == key.tag) || (entry_r.tag == mtmq_pkg::ANY_TAG) ||
             (key.tag == mtmq_pkg::ANY_TAG));
    end
  end

  assign hit_nxt  = cmp;
  assign hit_out  = hit_before | hit_r;
  assign free_out = free_before | ~entry_r.valid;

  // Removal shifts this and younger cells toward the head; append fills
  // the first free cell.
  always_comb begin
    entry_nxt = entry_r;
    if (upd.remove && (hit_before || hit_r)) begin
      entry_nxt = from_younger;
    end else if (upd.append && !entry_r.valid && !free_before) begin
      entry_nxt = upd.fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      hit_r         <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
      hit_r         <= hit_nxt;
    end
    entry_r.ctx  <= entry_nxt.ctx;
    entry_r.tag  <= entry_nxt.tag;
    entry_r.size <= entry_nxt.size;
    entry_r.id   <= entry_nxt.id;
  end

  assign entry   = entry_r;
  assign hit_reg = hit_r;

endmodule

// ----- hdl/mtmq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmq_queue
// An ordered chain of cells with a priority pick of the oldest hit.
// ----------------------------------------------------------------------------
module mtmq_queue #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mtmq_pkg::key_t   key,
  input  mtmq_pkg::upd_t   upd,
  output logic             found,
  output logic             full,
  output mtmq_pkg::entry_t pick
);

  mtmq_pkg::entry_t ent [DEPTH];
  logic [DEPTH:0]   hit_ch;
  logic [DEPTH:0]   free_ch;
  logic [DEPTH-1:0] hit_q;

  assign hit_ch[0]  = 1'b0;
  assign free_ch[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mtmq_pkg::entry_t younger;
    if (i == DEPTH - 1) begin : g_last
      assign younger = '0;
    end else begin : g_mid
      assign younger = ent[i+1];
    end
    mtmq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key         (key),
      .upd         (upd),
      .hit_before  (hit_ch[i]),
      .free_before (free_ch[i]),
      .from_younger(younger),
      .entry       (ent[i]),
      .hit_reg     (hit_q[i]),
      .hit_out     (hit_ch[i+1]),
      .free_out    (free_ch[i+1])
    );
  end

  assign found = hit_ch[DEPTH];
  assign full  = ~free_ch[DEPTH];

  // Oldest hit is the one whose older neighbors did not hit.
  always_comb begin
    pick = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_q[i] && !hit_ch[i]) begin
        pick = pick | ent[i];
      end
    end
  end

endmodule

// ----- hdl/message_tag_matching_queues_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_tag_matching_queues_top
// Send and receive queues with tag matching, probe and cancel.
// ----------------------------------------------------------------------------
// Each request goes from the start beat through SEARCH, which registers the
// compare in every cell of both queues, and RESOLVE, which picks the oldest
// hit and applies the update, to the result strobe after that. busy is high
// in SEARCH and RESOLVE and low again during the strobe cycle, so the next
// request can be accepted at the edge that ends the strobe.
// Every request gives exactly one result beat on out_valid; it cannot be
// stalled and must be taken in that cycle.
module message_tag_matching_queues_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_context_id,
  input  logic signed [15:0] in_tag,
  input  logic [31:0]        in_byte_size,
  input  logic [7:0]         in_handle,
  output logic               out_valid,
  output logic [2:0]         out_status_code,
  output logic [7:0]         out_matched_handle,
  output logic signed [15:0] out_result_tag,
  output logic [31:0]        out_byte_count
);

  mtmq_pkg::fsm_t   state_r, state_nxt;
  logic [2:0]       req_r;
  logic [15:0]      ctx_r, tag_r;
  logic [31:0]      size_r;
  logic [7:0]       id_r;
  mtmq_pkg::key_t   skey, rkey;
  mtmq_pkg::upd_t   supd, rupd;
  logic             s_found, s_full, r_found, r_full;
  mtmq_pkg::entry_t s_pick, r_pick;
  logic             resolve;
  logic             vld_r;
  logic [2:0]       st_r, st_nxt;
  logic [7:0]       mh_r, mh_nxt;
  logic [15:0]      rt_r, rt_nxt;
  logic [31:0]      bc_r, bc_nxt;

  // Request capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r  <= in_req_type;
      ctx_r  <= in_context_id;
      tag_r  <= in_tag;
      size_r <= in_byte_size;
      id_r   <= in_handle;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtmq_pkg::FSM_IDLE:    if (start) state_nxt = mtmq_pkg::FSM_SEARCH;
      mtmq_pkg::FSM_SEARCH:  state_nxt = mtmq_pkg::FSM_RESOLVE;
      mtmq_pkg::FSM_RESOLVE: state_nxt = mtmq_pkg::FSM_IDLE;
      default:               state_nxt = mtmq_pkg::FSM_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy    = 1'b0;
    resolve = 1'b0;
    unique case (state_r)
      mtmq_pkg::FSM_IDLE:    busy = 1'b0;
      mtmq_pkg::FSM_SEARCH:  busy = 1'b1;
      mtmq_pkg::FSM_RESOLVE: begin
        busy    = 1'b1;
        resolve = 1'b1;
      end
      default:               busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtmq_pkg::FSM_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= resolve;
    end
  end

  // Search keys: the send queue is searched by receives, probes and
  // send cancels; the receive queue by sends and receive cancels.
  always_comb begin
    skey.by_id = (req_r == mtmq_pkg::REQ_CANCEL_SEND);
    skey.ctx   = ctx_r;
    skey.tag   = tag_r;
    skey.id    = id_r;
    rkey.by_id = (req_r == mtmq_pkg::REQ_CANCEL_RECV);
    rkey.ctx   = ctx_r;
    rkey.tag   = tag_r;
    rkey.id    = id_r;
  end

  // Decide result and queue updates.
  always_comb begin
    supd        = '0;
    rupd        = '0;
    supd.fresh  = '{1'b1, ctx_r, tag_r, size_r, id_r};
    rupd.fresh  = '{1'b1, ctx_r, tag_r, size_r, id_r};
    st_nxt      = mtmq_pkg::ST_NOTFOUND;
    mh_nxt      = '0;
    rt_nxt      = '0;
    bc_nxt      = '0;
    case (req_r)
      mtmq_pkg::REQ_SEND: begin
        if (r_found) begin
          st_nxt      = (size_r > r_pick.size) ? mtmq_pkg::ST_TRUNC : mtmq_pkg::ST_MATCHED;
          bc_nxt      = (size_r > r_pick.size) ? r_pick.size : size_r;
          mh_nxt      = r_pick.id;
          rt_nxt      = tag_r;
          rupd.remove = resolve;
        end else if (s_full) begin
          st_nxt = mtmq_pkg::ST_FULL;
        end else begin
          st_nxt      = mtmq_pkg::ST_QUEUED;
          supd.append = resolve;
        end
      end
      mtmq_pkg::REQ_RECV: begin
        if (s_found) begin
          st_nxt      = (s_pick.size > size_r) ? mtmq_pkg::ST_TRUNC : mtmq_pkg::ST_MATCHED;
          bc_nxt      = (s_pick.size > size_r) ? size_r : s_pick.size;
          mh_nxt      = s_pick.id;
          rt_nxt      = s_pick.tag;
          supd.remove = resolve;
        end else if (r_full) begin
          st_nxt = mtmq_pkg::ST_FULL;
        end else begin
          st_nxt      = mtmq_pkg::ST_QUEUED;
          rupd.append = resolve;
        end
      end
      mtmq_pkg::REQ_PROBE, mtmq_pkg::REQ_MPROBE: begin
        if (s_found) begin
          st_nxt      = mtmq_pkg::ST_MATCHED;
          mh_nxt      = s_pick.id;
          rt_nxt      = s_pick.tag;
          bc_nxt      = s_pick.size;
          supd.remove = resolve && (req_r == mtmq_pkg::REQ_MPROBE);
        end
      end
      mtmq_pkg::REQ_CANCEL_SEND: begin
        if (s_found) begin
          st_nxt      = mtmq_pkg::ST_CANCELLED;
          mh_nxt      = id_r;
          supd.remove = resolve;
        end
      end
      mtmq_pkg::REQ_CANCEL_RECV: begin
        if (r_found) begin
          st_nxt      = mtmq_pkg::ST_CANCELLED;
          mh_nxt      = id_r;
          rupd.remove = resolve;
        end
      end
      default: st_nxt = mtmq_pkg::ST_NOTFOUND;
    endcase
  end

  mtmq_queue #(.DEPTH(QUEUE_DEPTH)) u_sendq (
    .clk  (clk),
    .rst_n(rst_n),
    .key  (skey),
    .upd  (supd),
    .found(s_found),
    .full (s_full),
    .pick (s_pick)
  );

  mtmq_queue #(.DEPTH(QUEUE_DEPTH)) u_recvq (
    .clk  (clk),
    .rst_n(rst_n),
    .key  (rkey),
    .upd  (rupd),
    .found(r_found),
    .full (r_full),
    .pick (r_pick)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (resolve) begin
      st_r <= st_nxt;
      mh_r <= mh_nxt;
      rt_r <= rt_nxt;
      bc_r <= bc_nxt;
    end
  end

  assign out_valid          = vld_r;
  assign out_status_code    = st_r;
  assign out_matched_handle = mh_r;
  assign out_result_tag     = rt_r;
  assign out_byte_count     = bc_r;

endmodule

// ----- hdl/mtmq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmq_checker
// Port-level checks of the request and result sequencing.
// ----------------------------------------------------------------------------
module mtmq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status_code
);

  // An accepted request raises busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

  // Each accepted request is followed by its result beat after the search and resolve steps.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid) else $error("result missing");

  // Results are single-cycle strobes.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

  // Status codes are in range.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_code <= 3'd5)) else $error("bad status");

endmodule

bind message_tag_matching_queues_top mtmq_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status_code(out_status_code)
);

// ----- tb/sv/tb_message_tag_matching_queues_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_tag_matching_queues_top
// Self-checking bench for the send and receive matching queues. A behavioral
// copy of both queues predicts every result beat, and each beat is compared
// field by field. Stimulus runs a directed part and then random traffic over
// a few contexts and tags, in several sender idling phases.
// ----------------------------------------------------------------------------
module tb_message_tag_matching_queues_top;

  localparam int DEPTH = 16;

  // One queued request as the bench sees it.
  typedef struct {
    logic [15:0] ctx;
    logic [15:0] tag;
    logic [31:0] size;
    logic [7:0]  id;
  } qent_t;

  // One result beat.
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  handle;
    logic [15:0] tag;
    logic [31:0] count;
  } answer_t;

  // Keeps both queues, predicts answers and checks result beats.
  class match_scoreboard;
    qent_t   sends[$];
    qent_t   recvs[$];
    answer_t pending[$];
    int      errors;
    int      beats;
    int      hits;
    int      fulls;

    function bit tag_hit(logic [15:0] a, logic [15:0] b);
      return a == b || a == mtmq_pkg::ANY_TAG || b == mtmq_pkg::ANY_TAG;
    endfunction

    function int find_key(ref qent_t q[$], input logic [15:0] c, input logic [15:0] t);
      foreach (q[i]) if (q[i].ctx == c && tag_hit(q[i].tag, t)) return i;
      return -1;
    endfunction

    function int find_handle(ref qent_t q[$], input logic [7:0] h);
      foreach (q[i]) if (q[i].id == h) return i;
      return -1;
    endfunction

    // Work out the answer of an accepted request and update the queues.
    function void note_request(logic [2:0] kind, logic [15:0] c, logic [15:0] t,
                               logic [31:0] sz, logic [7:0] h);
      answer_t a;
      qent_t   e;
      int      p;
      a = '{mtmq_pkg::ST_NOTFOUND, 8'd0, 16'd0, 32'd0};
      e = '{c, t, sz, h};
      case (kind)
        mtmq_pkg::REQ_SEND: begin
          p = find_key(recvs, c, t);
          if (p >= 0) begin
            a.status = sz > recvs[p].size ? mtmq_pkg::ST_TRUNC : mtmq_pkg::ST_MATCHED;
            a.count = sz > recvs[p].size ? recvs[p].size : sz;
            a.handle = recvs[p].id;
            a.tag = t;
            recvs.delete(p);
          end else if (sends.size() >= DEPTH) a.status = mtmq_pkg::ST_FULL;
          else begin
            sends.push_back(e);
            a.status = mtmq_pkg::ST_QUEUED;
          end
        end
        mtmq_pkg::REQ_RECV: begin
          p = find_key(sends, c, t);
          if (p >= 0) begin
            a.status = sends[p].size > sz ? mtmq_pkg::ST_TRUNC : mtmq_pkg::ST_MATCHED;
            a.count = sends[p].size > sz ? sz : sends[p].size;
            a.handle = sends[p].id;
            a.tag = sends[p].tag;
            sends.delete(p);
          end else if (recvs.size() >= DEPTH) a.status = mtmq_pkg::ST_FULL;
          else begin
            recvs.push_back(e);
            a.status = mtmq_pkg::ST_QUEUED;
          end
        end
        mtmq_pkg::REQ_PROBE, mtmq_pkg::REQ_MPROBE: begin
          p = find_key(sends, c, t);
          if (p >= 0) begin
            a = '{mtmq_pkg::ST_MATCHED, sends[p].id, sends[p].tag, sends[p].size};
            if (kind == mtmq_pkg::REQ_MPROBE) sends.delete(p);
          end
        end
        mtmq_pkg::REQ_CANCEL_SEND: begin
          p = find_handle(sends, h);
          if (p >= 0) begin
            a.status = mtmq_pkg::ST_CANCELLED;
            a.handle = h;
            sends.delete(p);
          end
        end
        mtmq_pkg::REQ_CANCEL_RECV: begin
          p = find_handle(recvs, h);
          if (p >= 0) begin
            a.status = mtmq_pkg::ST_CANCELLED;
            a.handle = h;
            recvs.delete(p);
          end
        end
        default: ;
      endcase
      if (a.status == mtmq_pkg::ST_MATCHED || a.status == mtmq_pkg::ST_TRUNC) hits++;
      if (a.status == mtmq_pkg::ST_FULL) fulls++;
      pending.push_back(a);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(answer_t got);
      answer_t w;
      beats++;
      if (pending.size() == 0) begin
        $error("result beat with no request waiting");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $error("status_code: expected %0d, got %0d", w.status, got.status);
        errors++;
      end
      if (got.handle !== w.handle) begin
        $error("matched_handle: expected %0d, got %0d", w.handle, got.handle);
        errors++;
      end
      if (got.tag !== w.tag) begin
        $error("result_tag: expected %h, got %h", w.tag, got.tag);
        errors++;
      end
      if (got.count !== w.count) begin
        $error("byte_count: expected %h, got %h", w.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_req_type = '0;
  logic [15:0]        in_context_id = '0;
  logic signed [15:0] in_tag = '0;
  logic [31:0]        in_byte_size = '0;
  logic [7:0]         in_handle = '0;
  logic               out_valid;
  logic [2:0]         out_status_code;
  logic [7:0]         out_matched_handle;
  logic signed [15:0] out_result_tag;
  logic [31:0]        out_byte_count;

  match_scoreboard board = new();
  int idle_pct = 0;

  message_tag_matching_queues_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_context_id(in_context_id), .in_tag(in_tag),
    .in_byte_size(in_byte_size), .in_handle(in_handle),
    .out_valid(out_valid), .out_status_code(out_status_code),
    .out_matched_handle(out_matched_handle), .out_result_tag(out_result_tag),
    .out_byte_count(out_byte_count)
  );

  always #1 clk = ~clk;

  // Result beats are taken at every edge where the strobe is high.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result('{out_status_code, out_matched_handle, out_result_tag,
                           out_byte_count});
  end

  // Drop start and put garbage on the payload while no beat is offered.
  task automatic idle_bus();
    start         <= 1'b0;
    in_req_type   <= 3'($urandom);
    in_context_id <= 16'($urandom);
    in_tag        <= 16'($urandom);
    in_byte_size  <= $urandom;
    in_handle     <= 8'($urandom);
  endtask

  // Present one request beat and hold it until the block takes it.
  task automatic issue(logic [2:0] kind, logic [15:0] c, logic [15:0] t,
                       logic [31:0] sz, logic [7:0] h);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      idle_bus();
      @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= kind;
    in_context_id <= c;
    in_tag        <= t;
    in_byte_size  <= sz;
    in_handle     <= h;
    do @(posedge clk); while (busy);
    board.note_request(kind, c, t, sz, h);
  endtask

  // Mostly well-formed traffic over few contexts and tags so that matches occur.
  task automatic random_request();
    logic [2:0]  kind;
    logic [15:0] c;
    logic [15:0] t;
    logic [31:0] sz;
    int          r;
    r = $urandom_range(99);
    if (r < 35) kind = mtmq_pkg::REQ_SEND;
    else if (r < 70) kind = mtmq_pkg::REQ_RECV;
    else if (r < 78) kind = mtmq_pkg::REQ_PROBE;
    else if (r < 85) kind = mtmq_pkg::REQ_MPROBE;
    else if (r < 91) kind = mtmq_pkg::REQ_CANCEL_SEND;
    else if (r < 97) kind = mtmq_pkg::REQ_CANCEL_RECV;
    else kind = 3'($urandom_range(7, 6));
    c = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(3));
    r = $urandom_range(9);
    if (r == 0) t = mtmq_pkg::ANY_TAG;
    else if (r == 1) t = 16'($urandom);
    else t = 16'($urandom_range(5));
    sz = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(4096));
    issue(kind, c, t, sz, 8'($urandom_range(1) ? $urandom_range(15) : $urandom));
  endtask

  initial begin
    #100000;
    $display("message_tag_matching_queues_top regression: fail");
    $finish;
  end

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases, extremes, wildcards, truncation, full, cancels.
    issue(mtmq_pkg::REQ_PROBE, 16'd0, 16'd0, 32'd0, 8'd0);
    issue(mtmq_pkg::REQ_CANCEL_SEND, 16'd0, 16'd0, 32'd0, 8'd255);
    issue(mtmq_pkg::REQ_CANCEL_RECV, 16'd0, 16'd0, 32'd0, 8'd0);
    issue(mtmq_pkg::REQ_SEND, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF, 8'd255);
    issue(mtmq_pkg::REQ_RECV, 16'hFFFF, mtmq_pkg::ANY_TAG, 32'd10, 8'd1);
    issue(mtmq_pkg::REQ_RECV, 16'd0, 16'h8000, 32'hFFFF_FFFF, 8'd2);
    issue(mtmq_pkg::REQ_SEND, 16'd0, mtmq_pkg::ANY_TAG, 32'd0, 8'd3);
    issue(mtmq_pkg::REQ_SEND, 16'd5, 16'h8000, 32'd7, 8'd4);
    issue(mtmq_pkg::REQ_PROBE, 16'd5, mtmq_pkg::ANY_TAG, 32'd0, 8'd0);
    issue(mtmq_pkg::REQ_MPROBE, 16'd5, 16'h8000, 32'd0, 8'd0);
    issue(mtmq_pkg::REQ_SEND, 16'd6, 16'd1, 32'd8, 8'd9);
    issue(mtmq_pkg::REQ_SEND, 16'd6, 16'd1, 32'd9, 8'd9);
    issue(mtmq_pkg::REQ_CANCEL_SEND, 16'd0, 16'd0, 32'd0, 8'd9);
    issue(mtmq_pkg::REQ_RECV, 16'd6, 16'd1, 32'd100, 8'd7);
    issue(3'd6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    issue(3'd7, 16'd0, 16'd0, 32'd0, 8'd0);
    for (int i = 0; i < DEPTH + 1; i++)
      issue(mtmq_pkg::REQ_RECV, 16'd9, 16'd2, 32'(i), 8'(i));
    issue(mtmq_pkg::REQ_CANCEL_RECV, 16'd0, 16'd0, 32'd0, 8'd4);
    for (int i = 0; i < DEPTH; i++)
      issue(mtmq_pkg::REQ_SEND, 16'd9, mtmq_pkg::ANY_TAG, 32'd8, 8'(i));

    // Random traffic through the idling phases: none, sender idle, a phase
    // with no idling since the receiver cannot stall, and light idling.
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 73 : (ph == 3 ? 7 : 0);
      repeat (100) begin
        random_request();
        n++;
      end
    end
    idle_bus();

    // Drain the last results.
    repeat (2000) begin
      if (board.pending.size() == 0) break;
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d results never arrived", board.pending.size());
      board.errors++;
    end
    $display("Covered %0d random requests and %0d result beats: %0d matches, %0d full.",
             n, board.beats, board.hits, board.fulls);
    if (board.errors == 0) $display("message_tag_matching_queues_top regression: pass");
    else $display("message_tag_matching_queues_top regression: fail");
    $finish;
  end
endmodule
